// ----- design/blci_pkg.sv -----
// Shared types, widths and encodings of the line walker with colour interpolation.
`default_nettype none
package blci_pkg;
    localparam int COORD_BITS   = 12;
    localparam int CHANNEL_BITS = 8;
    localparam int NUM_CHANNELS = 4;
    localparam int COLOR_BITS   = CHANNEL_BITS * NUM_CHANNELS;
    localparam int SPAN_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS     = COORD_BITS + 3;
    localparam int PROD_BITS    = CHANNEL_BITS + 1 + SPAN_BITS;
    localparam int QCNT_BITS    = $clog2(PROD_BITS + 1);
    localparam int CH_IDX_BITS  = $clog2(NUM_CHANNELS);
    localparam int REG_IDX_BITS = 1;

    localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic [COORD_BITS-1:0] WIDTH_RESET  = COORD_BITS'(1920);
    localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(1080);

    typedef enum logic [4:0] {
        t_ST_IDLE  = 5'b00001,
        t_ST_LOAD  = 5'b00010,
        t_ST_MUL   = 5'b00100,
        t_ST_DIV   = 5'b01000,
        t_ST_EMIT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;
endpackage
`default_nettype wire

// ----- design/blci_div.sv -----
// Restoring serial divider, one quotient bit per cycle, for the magnitude of a channel blend.
`default_nettype none
module blci_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [blci_pkg::PROD_BITS-1:0]    i_dividend,
    input  wire logic [blci_pkg::SPAN_BITS-1:0]    i_divisor,
    output blci_pkg::t_div_ctl                     o_ctl,
    output logic [blci_pkg::PROD_BITS-1:0]         o_quotient
);
    logic [blci_pkg::PROD_BITS-1:0] r_q, n_q;
    logic [blci_pkg::SPAN_BITS:0]   r_rem, n_rem;
    logic [blci_pkg::SPAN_BITS-1:0] r_div;
    logic [blci_pkg::QCNT_BITS-1:0] r_cnt, n_cnt;
    logic                           r_busy, n_busy, r_done, n_done;
    logic [blci_pkg::SPAN_BITS:0]   w_trial;

    always_comb begin
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[blci_pkg::SPAN_BITS-1:0], r_q[blci_pkg::PROD_BITS-1]};
        if (i_start) begin
            n_q = i_dividend;
            n_rem = '0;
            n_cnt = blci_pkg::QCNT_BITS'(blci_pkg::PROD_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_trial - {1'b0, r_div};
                n_q = {r_q[blci_pkg::PROD_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q = {r_q[blci_pkg::PROD_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == blci_pkg::QCNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_ctl.start = r_busy;
    assign o_ctl.done = r_done;
    assign o_quotient = r_q;
endmodule
`default_nettype wire

// ----- design/bresenham_line_color_interp.sv -----
// Top level of the line walker that gives one pixel per step item with an interpolated colour.
// A command channel (start, busy) takes items: kind 0 loads a line given by two endpoints
// and their colours, kind 1 asks for the next pixel. A load gives no result. A step with no
// line loaded gives no result. A step on a line emits one pixel on o_pixel_* with o_valid
// high for a single cycle; the receiver cannot stall and must take it then. The four colour
// channels are blended one after another: each is multiplied, the serial divider is started
// and retires the quotient bit by bit, and the quotient is taken. The pixel is registered
// onto the outputs as the block returns to idle. A single-point or zero-span line skips the
// divider. The divider sets the rate, and no new item is taken until the pixel is out. The
// configuration channel (i_cfg_valid, o_cfg_ready) writes the screen width (index 0) and
// height (index 1) and is always ready; the user must make writes only while the block is
// idle, and the block itself does not enforce it. Reset clears the line and sets the screen
// to 1920 by 1080. Pixels outside the screen are still emitted with o_visible low.
`default_nettype none
module bresenham_line_color_interp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 i_kind,
    input  wire logic signed [blci_pkg::COORD_BITS-1:0] i_x_start,
    input  wire logic signed [blci_pkg::COORD_BITS-1:0] i_y_start,
    input  wire logic signed [blci_pkg::COORD_BITS-1:0] i_x_end,
    input  wire logic signed [blci_pkg::COORD_BITS-1:0] i_y_end,
    input  wire logic [blci_pkg::COLOR_BITS-1:0]      i_color_start,
    input  wire logic [blci_pkg::COLOR_BITS-1:0]      i_color_end,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [blci_pkg::REG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [blci_pkg::COORD_BITS-1:0]      i_cfg_data,
    output logic                                      o_valid,
    output logic signed [blci_pkg::COORD_BITS-1:0]    o_pixel_x,
    output logic signed [blci_pkg::COORD_BITS-1:0]    o_pixel_y,
    output logic [blci_pkg::COLOR_BITS-1:0]           o_pixel_color,
    output logic                                      o_visible,
    output logic                                      o_last
);
    localparam int CB = blci_pkg::COORD_BITS;
    localparam int SB = blci_pkg::SPAN_BITS;
    localparam int EB = blci_pkg::ERR_BITS;
    localparam int HB = blci_pkg::CHANNEL_BITS;
    localparam int PB = blci_pkg::PROD_BITS;

    blci_pkg::t_state r_state;
    logic [CB-1:0] r_width, r_height;
    logic r_active, r_steep, r_msign;
    logic signed [CB-1:0] r_cx, r_cy, r_mend;
    logic [SB-1:0] r_dmaj, r_dmin, r_steps;
    logic signed [EB-1:0] r_err;
    logic [blci_pkg::COLOR_BITS-1:0] r_cfrom, r_cto, r_blend;
    logic [blci_pkg::CH_IDX_BITS-1:0] r_ch;
    logic r_neg;
    logic [PB-1:0] r_prod;
    logic signed [CB-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [blci_pkg::COLOR_BITS-1:0] r_c0, r_c1;

    logic signed [SB-1:0] w_dx, w_dy, w_adx, w_ady;
    logic w_steep, w_swap;
    logic signed [CB-1:0] w_ax, w_ay, w_bx, w_by;
    logic [SB-1:0] w_dmaj, w_dmin;
    logic [HB-1:0] w_a, w_b;
    logic signed [HB:0] w_diff;
    logic [HB-1:0] w_mag;
    logic [HB-1:0] w_q, w_res;
    logic w_fin, w_vis;
    logic signed [EB-1:0] w_err_inc;
    blci_pkg::t_div_ctl w_div;
    logic [PB-1:0] w_quot;
    logic w_div_go;

    assign o_cfg_ready = 1'b1;
    assign busy = (r_state != blci_pkg::t_ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= blci_pkg::WIDTH_RESET;
            r_height <= blci_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                blci_pkg::REG_SCREEN_WIDTH: r_width <= i_cfg_data;
                blci_pkg::REG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_dx = SB'(r_x1) - SB'(r_x0);
    assign w_dy = SB'(r_y1) - SB'(r_y0);
    assign w_adx = w_dx[SB-1] ? -w_dx : w_dx;
    assign w_ady = w_dy[SB-1] ? -w_dy : w_dy;
    assign w_steep = !(w_ady < w_adx);
    assign w_swap = w_steep ? (r_y0 > r_y1) : (r_x0 > r_x1);
    assign w_ax = w_swap ? r_x1 : r_x0;
    assign w_ay = w_swap ? r_y1 : r_y0;
    assign w_bx = w_swap ? r_x0 : r_x1;
    assign w_by = w_swap ? r_y0 : r_y1;
    assign w_dmaj = w_steep ? (SB'(w_by) - SB'(w_ay)) : (SB'(w_bx) - SB'(w_ax));
    assign w_dmin = w_steep ? w_adx : w_ady;

    assign w_a = r_cfrom[r_ch*HB +: HB];
    assign w_b = r_cto[r_ch*HB +: HB];
    assign w_diff = $signed({1'b0, w_b}) - $signed({1'b0, w_a});
    assign w_mag = w_diff[HB] ? HB'(-w_diff) : HB'(w_diff);
    assign w_q = (r_dmaj == '0) ? '0 : w_quot[HB-1:0];
    assign w_res = r_neg ? (w_a - w_q) : (w_a + w_q);

    assign w_fin = r_steep ? (r_cy >= r_mend) : (r_cx >= r_mend);
    assign w_vis = !r_cx[CB-1] && !r_cy[CB-1] && (r_cx < $signed({1'b0, r_width}))
                   && (r_cy < $signed({1'b0, r_height}))
                   && (r_width != '0) && (r_height != '0);
    assign w_err_inc = (r_err > 0) ? EB'(2 * ($signed({1'b0, r_dmin}) - $signed({1'b0, r_dmaj})))
                                   : EB'(2 * $signed({1'b0, r_dmin}));
    assign w_div_go = (r_state == blci_pkg::t_ST_DIV) && (r_dmaj != '0)
                      && !w_div.start && !w_div.done;

    blci_div u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_go),
        .i_dividend(r_prod),
        .i_divisor(r_dmaj),
        .o_ctl(w_div),
        .o_quotient(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blci_pkg::t_ST_IDLE;
            r_active <= 1'b0;
            o_valid <= 1'b0;
            r_ch <= '0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                blci_pkg::t_ST_IDLE: begin
                    if (start) begin
                        r_x0 <= i_x_start;
                        r_y0 <= i_y_start;
                        r_x1 <= i_x_end;
                        r_y1 <= i_y_end;
                        r_c0 <= i_color_start;
                        r_c1 <= i_color_end;
                        if (i_kind == blci_pkg::KIND_LOAD) begin
                            r_state <= blci_pkg::t_ST_LOAD;
                        end else if (r_active) begin
                            r_ch <= '0;
                            r_state <= blci_pkg::t_ST_MUL;
                        end
                    end
                end
                blci_pkg::t_ST_LOAD: begin
                    r_steep <= w_steep;
                    r_dmaj <= w_dmaj;
                    r_dmin <= w_dmin;
                    r_msign <= w_steep ? (w_bx < w_ax) : (w_by < w_ay);
                    r_mend <= w_steep ? w_by : w_bx;
                    r_err <= EB'(2 * $signed({1'b0, w_dmin})) - EB'($signed({1'b0, w_dmaj}));
                    r_cx <= w_ax;
                    r_cy <= w_ay;
                    r_steps <= '0;
                    r_cfrom <= w_swap ? r_c1 : r_c0;
                    r_cto <= w_swap ? r_c0 : r_c1;
                    r_active <= 1'b1;
                    r_state <= blci_pkg::t_ST_IDLE;
                end
                blci_pkg::t_ST_MUL: begin
                    r_neg <= w_diff[HB];
                    r_prod <= PB'(w_mag) * PB'(r_steps);
                    r_state <= blci_pkg::t_ST_DIV;
                end
                blci_pkg::t_ST_DIV: begin
                    if (w_div.done || (r_dmaj == '0 && !w_div.start)) begin
                        r_blend[r_ch*HB +: HB] <= w_res;
                        r_ch <= r_ch + 1'b1;
                        r_state <= (r_ch == blci_pkg::CH_IDX_BITS'(blci_pkg::NUM_CHANNELS - 1))
                                   ? blci_pkg::t_ST_EMIT : blci_pkg::t_ST_MUL;
                    end
                end
                blci_pkg::t_ST_EMIT: begin
                    o_valid <= 1'b1;
                    o_pixel_x <= r_cx;
                    o_pixel_y <= r_cy;
                    o_pixel_color <= r_blend;
                    o_visible <= w_vis;
                    o_last <= w_fin;
                    if (w_fin) begin
                        r_active <= 1'b0;
                    end else begin
                        if (r_err > 0) begin
                            if (r_steep) r_cx <= r_cx + (r_msign ? -CB'(1) : CB'(1));
                            else r_cy <= r_cy + (r_msign ? -CB'(1) : CB'(1));
                        end
                        if (r_steep) r_cy <= r_cy + CB'(1);
                        else r_cx <= r_cx + CB'(1);
                        r_err <= r_err + w_err_inc;
                        r_steps <= r_steps + 1'b1;
                    end
                    r_state <= blci_pkg::t_ST_IDLE;
                end
                default: r_state <= blci_pkg::t_ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/blci_checker.sv -----
// Port-level checks of the line walker, bound to the top level.
`default_nettype none
module blci_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_kind,
    input wire logic o_valid,
    input wire logic o_last
);
    a_no_busy_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !busy && !o_valid)
        else $error("busy or valid after reset");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == blci_pkg::KIND_LOAD) |=> busy)
        else $error("accepted load did not raise busy");
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result held longer than one cycle");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last && o_valid |=> !o_valid)
        else $error("result right after last");
endmodule

bind bresenham_line_color_interp blci_checker u_blci_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .i_kind(i_kind),
    .o_valid(o_valid),
    .o_last(o_last)
);
`default_nettype wire
